// ===== hdl/id_bitmap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// id_bitmap_allocator_defines.svh
// Assertion macros shared by the identifier allocator modules.
// ----------------------------------------------------------------------------
`ifndef ID_BITMAP_ALLOCATOR_DEFINES_SVH
`define ID_BITMAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IBA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("id allocator check failed");
// next-cycle implication
`define IBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("id allocator check failed");
`else
`define IBA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define IBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/iba_pkg.sv =====
// ----------------------------------------------------------------------------
// iba_pkg
// Types and constants of the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package iba_pkg;

    localparam int ID_W          = 16;
    localparam int OP_W          = 2;
    localparam int ID_COUNT_DEF  = 65536;
    localparam int WORD_BITS_DEF = 32;

    // one summary row covers this many map words
    localparam int SUM_W     = 64;
    localparam int SUM_COL_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CLAIM   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TAKE    = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ADDR,
        S_ROW,
        S_WORD,
        S_UPDATE,
        S_FAIL
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic divide;
        logic address;
        logic row_read;
        logic word_read;
        logic update;
        logic fail;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic group_empty;
        logic slot_free;
    } dp_status_t;

endpackage

// ===== hdl/iba_ctrl.sv =====
// ----------------------------------------------------------------------------
// iba_ctrl
// Sequencer of the allocator: clearing pass, then one operation at a time.
// ----------------------------------------------------------------------------
`include "id_bitmap_allocator_defines.svh"

module iba_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [iba_pkg::OP_W-1:0] operation,
    output iba_pkg::dp_cmd_t         cmd,
    input  iba_pkg::dp_status_t      status
);

    iba_pkg::state_t state_reg;
    iba_pkg::state_t state_next;
    iba_pkg::op_t    op_reg;
    iba_pkg::op_t    op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iba_pkg::S_CLEAR;
            op_reg    <= iba_pkg::OP_CLAIM;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            iba_pkg::S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = iba_pkg::S_IDLE;
                end
            end
            iba_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (operation)
                        iba_pkg::OP_CLAIM, iba_pkg::OP_RELEASE:
                        begin
                            op_next    = iba_pkg::op_t'(operation);
                            state_next = iba_pkg::S_DIV;
                        end
                        iba_pkg::OP_TAKE:
                        begin
                            op_next    = iba_pkg::OP_TAKE;
                            state_next = iba_pkg::S_ROW;
                        end
                        default:
                        begin
                            // undefined code: fail and echo the id
                            op_next    = iba_pkg::OP_CLAIM;
                            state_next = iba_pkg::S_FAIL;
                        end
                    endcase
                end
            end
            iba_pkg::S_DIV:
            begin
                cmd.divide = 1'b1;
                state_next = iba_pkg::S_ADDR;
            end
            iba_pkg::S_ADDR:
            begin
                cmd.address = 1'b1;
                state_next  = iba_pkg::S_UPDATE;
            end
            iba_pkg::S_ROW:
            begin
                if (status.group_empty)
                begin
                    state_next = iba_pkg::S_FAIL;
                end
                else
                begin
                    cmd.row_read = 1'b1;
                    state_next   = iba_pkg::S_WORD;
                end
            end
            iba_pkg::S_WORD:
            begin
                cmd.word_read = 1'b1;
                state_next    = iba_pkg::S_UPDATE;
            end
            iba_pkg::S_UPDATE:
            begin
                if (status.slot_free)
                begin
                    cmd.update = 1'b1;
                    state_next = iba_pkg::S_IDLE;
                end
            end
            iba_pkg::S_FAIL:
            begin
                if (status.slot_free)
                begin
                    cmd.fail   = 1'b1;
                    state_next = iba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = iba_pkg::S_IDLE;
            end
        endcase
    end

    `IBA_ASSERT_NEXT(a_clear_once, clk, rst_n, state_reg != iba_pkg::S_CLEAR, state_reg != iba_pkg::S_CLEAR)
    `IBA_ASSERT_IMPLY(a_result_slot, clk, rst_n, cmd.update || cmd.fail, status.slot_free)
    `IBA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, state_reg == iba_pkg::S_IDLE && in_valid, state_reg != iba_pkg::S_IDLE)

endmodule

// ===== hdl/iba_datapath.sv =====
// ----------------------------------------------------------------------------
// iba_datapath
// Free bitmap memory, per-word summary rows, row summary flops, index
// arithmetic and the result register.
// ----------------------------------------------------------------------------
`include "id_bitmap_allocator_defines.svh"

module iba_datapath #(
    parameter int ID_COUNT  = iba_pkg::ID_COUNT_DEF,
    parameter int WORD_BITS = iba_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  iba_pkg::dp_cmd_t         cmd,
    output iba_pkg::dp_status_t      status,
    input  logic [iba_pkg::ID_W-1:0] requested_id,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     success,
    output logic [iba_pkg::ID_W-1:0] granted_id
);

    localparam int ID_W          = iba_pkg::ID_W;
    localparam int SUM_W         = iba_pkg::SUM_W;
    localparam int SUM_COL_W     = iba_pkg::SUM_COL_W;
    localparam int NUM_WORDS     = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int NUM_ROWS      = (NUM_WORDS + SUM_W - 1) / SUM_W;
    localparam int ROW_W         = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int SW_W          = ROW_W + SUM_COL_W;
    // id / WORD_BITS as a multiply by a rounded-up reciprocal, exact for ID_W bits
    localparam int SHIFT         = ID_W + BIT_W;
    localparam int RECIP         = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W       = ID_W + 2;
    localparam int PROD_W        = ID_W + RECIP_W;
    localparam int LAST_BITS     = ID_COUNT - (NUM_WORDS - 1) * WORD_BITS;
    localparam int LAST_ROW_BITS = NUM_WORDS - (NUM_ROWS - 1) * SUM_W;

    localparam logic [WORD_BITS-1:0] LAST_MASK   = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
    localparam logic [WORD_BITS-1:0] LOW_MASK    = {WORD_BITS{1'b1}} << 2;
    localparam logic [WORD_BITS-1:0] RESET_WORD0 = ~({{(WORD_BITS-2){1'b0}}, 2'b10});
    localparam logic [SUM_W-1:0]     LAST_ROW_MASK = {SUM_W{1'b1}} >> (SUM_W - LAST_ROW_BITS);
    localparam logic [ID_W:0]        ID_LIMIT    = (ID_W+1)'(ID_COUNT);

    logic [WORD_BITS-1:0] free_mem [NUM_WORDS];
    logic [SUM_W-1:0]     sum_mem  [NUM_ROWS];

    logic [ID_W-1:0]      id_reg;
    logic [WIDX_W-1:0]    q_reg;
    logic [WIDX_W-1:0]    w_reg;
    logic [BIT_W-1:0]     b_reg;
    logic                 in_range_reg;
    logic [ROW_W-1:0]     r_reg;
    logic [WORD_BITS-1:0] word_q_reg;
    logic [SUM_W-1:0]     row_q_reg;
    logic [WIDX_W-1:0]    clr_cnt_reg;
    logic [NUM_ROWS-1:0]  group_reg;
    logic                 out_valid_reg;
    logic                 success_reg;
    logic [ID_W-1:0]      granted_reg;

    logic [PROD_W-1:0]    prod;
    logic [WIDX_W-1:0]    q_next;
    logic [ID_W-1:0]      rem;
    logic [ROW_W-1:0]     r_sel;
    logic [SUM_COL_W-1:0] k_sel;
    logic [SW_W-1:0]      w_take_ext;
    logic [WIDX_W-1:0]    w_take;
    logic [SW_W-1:0]      q_ext;
    logic [SW_W-1:0]      w_ext;
    logic [SW_W-1:0]      clr_ext;
    logic [WORD_BITS-1:0] wmask;
    logic [WORD_BITS-1:0] masked_word;
    logic [BIT_W-1:0]     take_b;
    logic [BIT_W-1:0]     bsel;
    logic [WORD_BITS-1:0] bit_onehot;
    logic                 hit;
    logic [WORD_BITS-1:0] new_word;
    logic [SUM_W-1:0]     new_row;
    logic                 do_write;
    logic                 success_next;
    logic [ID_W-1:0]      granted_next;
    logic                 is_take;
    logic                 is_release;
    logic                 slot_free;

    logic                 fmem_we;
    logic [WIDX_W-1:0]    fmem_waddr;
    logic [WORD_BITS-1:0] fmem_wdata;
    logic                 fmem_re;
    logic [WIDX_W-1:0]    fmem_raddr;
    logic                 smem_we;
    logic [ROW_W-1:0]     smem_waddr;
    logic [SUM_W-1:0]     smem_wdata;
    logic                 smem_re;
    logic [ROW_W-1:0]     smem_raddr;

    assign is_take    = (cmd.op == iba_pkg::OP_TAKE);
    assign is_release = (cmd.op == iba_pkg::OP_RELEASE);
    assign slot_free  = !out_valid_reg || !out_stall;

    // word index of a claim or release
    assign prod   = PROD_W'(id_reg) * PROD_W'(RECIP);
    assign q_next = WIDX_W'(prod >> SHIFT);
    assign rem    = id_reg - ID_W'(ID_W'(q_reg) * ID_W'(WORD_BITS));

    assign q_ext   = SW_W'(q_reg);
    assign w_ext   = SW_W'(w_reg);
    assign clr_ext = SW_W'(clr_cnt_reg);

    // lowest row with a free id
    always_comb
    begin
        r_sel = '0;
        for (int i = NUM_ROWS - 1; i >= 0; i--)
        begin
            if (group_reg[i])
            begin
                r_sel = ROW_W'(i);
            end
        end
    end

    // lowest word of that row with a free id
    always_comb
    begin
        k_sel = '0;
        for (int i = SUM_W - 1; i >= 0; i--)
        begin
            if (row_q_reg[i])
            begin
                k_sel = SUM_COL_W'(i);
            end
        end
    end

    assign w_take_ext = {r_reg, k_sel};
    assign w_take     = w_take_ext[WIDX_W-1:0];

    // ids that take-lowest may hand out in the current word
    always_comb
    begin
        wmask = '1;
        if (w_reg == WIDX_W'(NUM_WORDS - 1))
        begin
            wmask = wmask & LAST_MASK;
        end
        if (w_reg == '0)
        begin
            wmask = wmask & LOW_MASK;
        end
    end

    assign masked_word = word_q_reg & wmask;

    always_comb
    begin
        take_b = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (masked_word[i])
            begin
                take_b = BIT_W'(i);
            end
        end
    end

    assign bsel       = is_take ? take_b : b_reg;
    assign bit_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << bsel;
    assign hit        = |(word_q_reg & bit_onehot);
    assign new_word   = is_release ? (word_q_reg | bit_onehot) : (word_q_reg & ~bit_onehot);

    always_comb
    begin
        new_row = row_q_reg;
        new_row[w_ext[SUM_COL_W-1:0]] = |(new_word & wmask);
    end

    always_comb
    begin
        case (cmd.op)
            iba_pkg::OP_TAKE:
            begin
                do_write     = 1'b1;
                success_next = 1'b1;
                granted_next = ID_W'(ID_W'(w_reg) * ID_W'(WORD_BITS)) + ID_W'(take_b);
            end
            iba_pkg::OP_RELEASE:
            begin
                do_write     = in_range_reg;
                success_next = 1'b1;
                granted_next = id_reg;
            end
            default:
            begin
                do_write     = in_range_reg && hit;
                success_next = in_range_reg && hit;
                granted_next = id_reg;
            end
        endcase
    end

    // memory ports
    always_comb
    begin
        fmem_we    = cmd.clear || (cmd.update && do_write);
        fmem_waddr = cmd.clear ? clr_cnt_reg : w_reg;
        if (cmd.clear)
        begin
            fmem_wdata = (clr_cnt_reg == '0) ? RESET_WORD0 : {WORD_BITS{1'b1}};
        end
        else
        begin
            fmem_wdata = new_word;
        end
        fmem_re    = cmd.address || cmd.word_read;
        fmem_raddr = cmd.address ? q_reg : w_take;

        smem_we    = (cmd.clear && (clr_ext < SW_W'(NUM_ROWS))) || (cmd.update && do_write);
        smem_waddr = cmd.clear ? clr_ext[ROW_W-1:0] : w_ext[SW_W-1:SUM_COL_W];
        if (cmd.clear)
        begin
            smem_wdata = (clr_ext == SW_W'(NUM_ROWS - 1)) ? LAST_ROW_MASK : {SUM_W{1'b1}};
        end
        else
        begin
            smem_wdata = new_row;
        end
        smem_re    = cmd.address || cmd.row_read;
        smem_raddr = cmd.address ? q_ext[SW_W-1:SUM_COL_W] : r_sel;
    end

    always_ff @(posedge clk)
    begin
        if (fmem_we)
        begin
            free_mem[fmem_waddr] <= fmem_wdata;
        end
        if (fmem_re)
        begin
            word_q_reg <= free_mem[fmem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            sum_mem[smem_waddr] <= smem_wdata;
        end
        if (smem_re)
        begin
            row_q_reg <= sum_mem[smem_raddr];
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            id_reg <= requested_id;
        end
        if (cmd.divide)
        begin
            q_reg <= q_next;
        end
        if (cmd.address)
        begin
            w_reg        <= q_reg;
            b_reg        <= rem[BIT_W-1:0];
            in_range_reg <= ({1'b0, id_reg} < ID_LIMIT);
        end
        if (cmd.row_read)
        begin
            r_reg <= r_sel;
        end
        if (cmd.word_read)
        begin
            w_reg <= w_take;
        end
        if (cmd.update || cmd.fail)
        begin
            success_reg <= cmd.update ? success_next : 1'b0;
            if (cmd.update)
            begin
                granted_reg <= granted_next;
            end
            else
            begin
                granted_reg <= is_take ? '0 : id_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            group_reg     <= {NUM_ROWS{1'b1}};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + WIDX_W'(1);
            end
            if (cmd.update && do_write)
            begin
                group_reg[w_ext[SW_W-1:SUM_COL_W]] <= |new_row;
            end
            if (cmd.update || cmd.fail)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last  = (clr_cnt_reg == WIDX_W'(NUM_WORDS - 1));
    assign status.group_empty = (group_reg == '0);
    assign status.slot_free   = slot_free;

    assign out_valid  = out_valid_reg;
    assign success    = success_reg;
    assign granted_id = granted_reg;

    `IBA_ASSERT_IMPLY(a_take_word_free, clk, rst_n, cmd.update && is_take, masked_word != '0)
    `IBA_ASSERT_IMPLY(a_row_nonempty, clk, rst_n, cmd.word_read, row_q_reg != '0)
    `IBA_ASSERT_NEXT(a_result_loaded, clk, rst_n, cmd.update || cmd.fail, out_valid_reg)

endmodule

// ===== hdl/id_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// id_bitmap_allocator
// Allocator of 16-bit identifiers kept in a free bitmap with per-word summary.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the bitmap memory, one word
// per cycle, with in_stall high. From then on one operation is handled at a
// time: the accept cycle, then three steps of a read, modify and write of one
// bitmap word and its summary row (claim and release: word index multiply,
// address and read, update; take-lowest: row pick and summary read, word pick
// and bitmap read, update). An undefined code, or a take-lowest with no free
// id, ends in a fail step instead. The result sits in an output register, so
// a new beat is accepted while the previous result waits; the update or fail
// step waits only while that register is full and out_stall is high.
`include "id_bitmap_allocator_defines.svh"

module id_bitmap_allocator #(
    parameter int ID_COUNT  = iba_pkg::ID_COUNT_DEF,
    parameter int WORD_BITS = iba_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [iba_pkg::OP_W-1:0] operation,
    input  logic [iba_pkg::ID_W-1:0] requested_id,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     success,
    output logic [iba_pkg::ID_W-1:0] granted_id
);

    iba_pkg::dp_cmd_t    cmd;
    iba_pkg::dp_status_t status;

    iba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .cmd       (cmd),
        .status    (status)
    );

    iba_datapath #(
        .ID_COUNT  (ID_COUNT),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .requested_id (requested_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .success      (success),
        .granted_id   (granted_id)
    );

endmodule
